// ===== rtl/bwrs_pkg.sv =====
// ----------------------------------------------------------------------------
// bwrs_pkg
// Shared widths, micro-op codes and the control store for the range splitter.
// ----------------------------------------------------------------------------
package bwrs_pkg;

    localparam int COUNT_W       = 32;
    localparam int DIVIDEND_W    = COUNT_W + 1;           // ceiling sum needs one more bit
    localparam int MAX_WORKERS   = 64;
    localparam int WORKERS_W     = $clog2(MAX_WORKERS + 1);
    localparam int INDEX_W       = $clog2(MAX_WORKERS);
    localparam int CFG_W         = 7;
    localparam int DEFAULT_BATCH = 64;
    localparam int RESET_LIMIT   = 8;
    localparam int DIV_STEPS     = DIVIDEND_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int STEP_W        = 3;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [2:0] {
        OP_ACCEPT,      // take an input item
        OP_LOAD_CEIL,   // start (total + batch - 1) / batch
        OP_WAIT_DIV,    // let the divider run
        OP_LOAD_SPLIT,  // clamp worker count, start total / workers
        OP_SETUP,       // latch per-worker count and remainder
        OP_EMIT         // one range per free output slot
    } t_op;

    typedef enum logic [1:0] {
        HOLD_NEVER,
        HOLD_NO_ITEM,   // no accepted item, or an empty one
        HOLD_DIV_BUSY,
        HOLD_EMIT       // until the final range is loaded
    } t_hold;

    typedef struct packed {
        t_op   op;
        t_hold hold;
        t_step next;
    } t_uword;

    localparam t_step STEP_IDLE  = t_step'(0);
    localparam t_step STEP_CEIL  = t_step'(1);
    localparam t_step STEP_DIV1  = t_step'(2);
    localparam t_step STEP_SPLIT = t_step'(3);
    localparam t_step STEP_DIV2  = t_step'(4);
    localparam t_step STEP_SETUP = t_step'(5);
    localparam t_step STEP_EMIT  = t_step'(6);

    function automatic t_uword uc_rom(input t_step s);
        t_uword w;
        unique case (s)
            STEP_IDLE:  w = '{op: OP_ACCEPT,     hold: HOLD_NO_ITEM,  next: STEP_CEIL};
            STEP_CEIL:  w = '{op: OP_LOAD_CEIL,  hold: HOLD_NEVER,    next: STEP_DIV1};
            STEP_DIV1:  w = '{op: OP_WAIT_DIV,   hold: HOLD_DIV_BUSY, next: STEP_SPLIT};
            STEP_SPLIT: w = '{op: OP_LOAD_SPLIT, hold: HOLD_NEVER,    next: STEP_DIV2};
            STEP_DIV2:  w = '{op: OP_WAIT_DIV,   hold: HOLD_DIV_BUSY, next: STEP_SETUP};
            STEP_SETUP: w = '{op: OP_SETUP,      hold: HOLD_NEVER,    next: STEP_EMIT};
            STEP_EMIT:  w = '{op: OP_EMIT,       hold: HOLD_EMIT,     next: STEP_IDLE};
            default:    w = '{op: OP_ACCEPT,     hold: HOLD_NEVER,    next: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/bwrs_div.sv =====
// ----------------------------------------------------------------------------
// bwrs_div
// Restoring divider, one quotient bit per cycle; divisor must be nonzero.
// ----------------------------------------------------------------------------
module bwrs_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [bwrs_pkg::DIVIDEND_W-1:0]   i_dividend,
    input  logic [bwrs_pkg::COUNT_W-1:0]      i_divisor,
    output logic                              o_busy,
    output logic [bwrs_pkg::DIVIDEND_W-1:0]   o_quotient,
    output logic [bwrs_pkg::COUNT_W-1:0]      o_remainder
);
    import bwrs_pkg::*;

    logic                  r_busy,  n_busy;
    logic [DIV_CNT_W-1:0]  r_cnt,   n_cnt;
    logic [DIVIDEND_W-1:0] r_quo,   n_quo;
    logic [COUNT_W-1:0]    r_rem,   n_rem;
    logic [COUNT_W-1:0]    r_dvs,   n_dvs;

    logic [DIVIDEND_W-1:0] w_shift;
    logic [DIVIDEND_W-1:0] w_diff;
    logic                  w_ge;

    // partial remainder stays below the divisor, so the shifted value fits 33 bits
    assign w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_STEPS);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo  = {r_quo[DIVIDEND_W-2:0], w_ge};
            n_rem  = w_ge ? w_diff[COUNT_W-1:0] : w_shift[COUNT_W-1:0];
            n_cnt  = r_cnt - DIV_CNT_W'(1);
            n_busy = r_cnt != DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== rtl/balanced_work_range_splitter.sv =====
// ----------------------------------------------------------------------------
// balanced_work_range_splitter
// Splits a work item count into balanced contiguous ranges, one per worker.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): total_count and min_batch. An item
// with total_count of zero is taken and produces nothing. Output channel
// (o_out_valid / i_out_ready): one range per worker in worker order, the
// final one flagged by o_last_range. Config channel (i_cfg_valid /
// o_cfg_ready, always ready): the worker limit, reset value 8; 0 acts as 1,
// values above 64 act as 64. Write it only while idle.
// Steps: accept, load and wait out the ceiling division on the shared serial
// divider, load and wait out the split division, set up, then emit one range
// per cycle while the output is not stalled. A new item is taken only once
// the final range is in the output register.
// The output register holds its range while i_out_ready is low and the
// sequencer waits on it. Reset returns the step counter to idle, clears the
// output valid and restores the limit to 8.
// ----------------------------------------------------------------------------
module balanced_work_range_splitter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [bwrs_pkg::COUNT_W-1:0]       i_total_count,
    input  logic [bwrs_pkg::COUNT_W-1:0]       i_min_batch,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [bwrs_pkg::INDEX_W-1:0]       o_worker_index,
    output logic [bwrs_pkg::COUNT_W-1:0]       o_range_start,
    output logic [bwrs_pkg::COUNT_W-1:0]       o_range_count,
    output logic                               o_last_range,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bwrs_pkg::CFG_W-1:0]         i_cfg_data
);
    import bwrs_pkg::*;

    t_step                 r_step, n_step;
    logic [CFG_W-1:0]      r_max_workers;
    logic [COUNT_W-1:0]    r_total, r_batch;
    logic [WORKERS_W-1:0]  r_workers;
    logic [COUNT_W-1:0]    r_per;
    logic [INDEX_W-1:0]    r_rem;
    logic [INDEX_W-1:0]    r_idx;
    logic [COUNT_W-1:0]    r_start;
    logic                  r_out_valid;
    logic [INDEX_W-1:0]    r_o_index;
    logic [COUNT_W-1:0]    r_o_start, r_o_count;
    logic                  r_o_last;

    t_uword                w_uw;
    logic                  w_accept, w_ld_ceil, w_ld_split, w_setup, w_emit;
    logic                  w_hold, w_out_free, w_in_ready;
    logic                  w_div_start, w_div_busy;
    logic [DIVIDEND_W-1:0] w_dividend, w_quo;
    logic [COUNT_W-1:0]    w_divisor, w_div_rem;
    logic [WORKERS_W-1:0]  w_limit, w_clamped;
    logic [COUNT_W-1:0]    w_cnt;
    logic                  w_last;

    assign w_uw       = uc_rom(r_step);
    assign w_out_free = !r_out_valid || i_out_ready;

    // micro-op decode
    always_comb begin
        w_in_ready = 1'b0;
        w_ld_ceil  = 1'b0;
        w_ld_split = 1'b0;
        w_setup    = 1'b0;
        w_emit     = 1'b0;
        unique case (w_uw.op)
            OP_ACCEPT:     w_in_ready = 1'b1;
            OP_LOAD_CEIL:  w_ld_ceil  = 1'b1;
            OP_WAIT_DIV:   ;
            OP_LOAD_SPLIT: w_ld_split = 1'b1;
            OP_SETUP:      w_setup    = 1'b1;
            OP_EMIT:       w_emit     = w_out_free;
            default:       ;
        endcase
    end

    assign w_accept = w_in_ready && i_in_valid;

    always_comb begin
        unique case (w_uw.hold)
            HOLD_NEVER:    w_hold = 1'b0;
            HOLD_NO_ITEM:  w_hold = !w_accept || (i_total_count == '0);
            HOLD_DIV_BUSY: w_hold = w_div_busy;
            HOLD_EMIT:     w_hold = !(w_emit && w_last);
            default:       w_hold = 1'b0;
        endcase
    end

    assign n_step = w_hold ? r_step : w_uw.next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // effective limit: zero acts as one, saturate at the maximum
    always_comb begin
        if (r_max_workers > CFG_W'(MAX_WORKERS)) begin
            w_limit = WORKERS_W'(MAX_WORKERS);
        end else if (r_max_workers == '0) begin
            w_limit = WORKERS_W'(1);
        end else begin
            w_limit = WORKERS_W'(r_max_workers);
        end
    end

    // ceiling quotient is at least one since total is nonzero
    assign w_clamped = (w_quo > DIVIDEND_W'(w_limit)) ? w_limit : w_quo[WORKERS_W-1:0];

    assign w_div_start = w_ld_ceil || w_ld_split;
    assign w_dividend  = w_ld_ceil ? ({1'b0, r_total} + {1'b0, r_batch} - DIVIDEND_W'(1))
                                   : {1'b0, r_total};
    assign w_divisor   = w_ld_ceil ? r_batch : COUNT_W'(w_clamped);

    bwrs_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_busy      (w_div_busy),
        .o_quotient  (w_quo),
        .o_remainder (w_div_rem)
    );

    assign w_cnt  = r_per + COUNT_W'(r_idx < r_rem);
    assign w_last = ({1'b0, r_idx} + WORKERS_W'(1)) == r_workers;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_total <= i_total_count;
            r_batch <= (i_min_batch == '0) ? COUNT_W'(DEFAULT_BATCH) : i_min_batch;
        end
        if (w_ld_split) begin
            r_workers <= w_clamped;
        end
        if (w_setup) begin
            r_per   <= w_quo[COUNT_W-1:0];
            r_rem   <= w_div_rem[INDEX_W-1:0];
            r_idx   <= '0;
            r_start <= '0;
        end else if (w_emit) begin
            r_idx   <= r_idx + INDEX_W'(1);
            r_start <= r_start + w_cnt;
        end
        if (w_emit) begin
            r_o_index <= r_idx;
            r_o_start <= r_start;
            r_o_count <= w_cnt;
            r_o_last  <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_max_workers <= CFG_W'(RESET_LIMIT);
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_max_workers <= i_cfg_data;
            end
        end
    end

    assign o_in_ready     = w_in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_worker_index = r_o_index;
    assign o_range_start  = r_o_start;
    assign o_range_count  = r_o_count;
    assign o_last_range   = r_o_last;
    assign o_cfg_ready    = 1'b1;

endmodule

// ===== rtl/bwrs_checker.sv =====
// ----------------------------------------------------------------------------
// bwrs_checker
// Port-level checks on the range splitter, bound to the top level.
// ----------------------------------------------------------------------------
module bwrs_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [bwrs_pkg::INDEX_W-1:0]  o_worker_index,
    input  logic [bwrs_pkg::COUNT_W-1:0]  o_range_start,
    input  logic [bwrs_pkg::COUNT_W-1:0]  o_range_count,
    input  logic                          o_last_range
);
    import bwrs_pkg::*;

    // a stalled range keeps its offset
    a_hold_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_range_start))
        else $error("range start changed while stalled");

    // the first worker always starts at offset zero
    a_first_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_worker_index == '0 |-> o_range_start == '0)
        else $error("first range does not start at zero");

    // workers never exceed the item count, so no range is empty
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_range_count != '0)
        else $error("empty range emitted");

    // no new item is taken while a split is still being emitted
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_range |-> !o_in_ready)
        else $error("input ready in the middle of a split");

endmodule

bind balanced_work_range_splitter bwrs_checker u_bwrs_checker (.*);
